### design/rdt_pkg.sv
// shared types and constants of the repeating delay timer
`default_nettype none
package rdt_pkg;

  localparam int unsigned TickW     = 32;
  localparam int unsigned TimeW     = 40;
  localparam int unsigned CountW    = 32;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 32;
  localparam int unsigned MaxFiresDef = 64;

  // register indexes
  localparam logic [CfgIdxW-1:0] RegInterval = 2'd0;
  localparam logic [CfgIdxW-1:0] RegDelay    = 2'd1;
  localparam logic [CfgIdxW-1:0] RegRepeat   = 2'd2;
  localparam logic [CfgIdxW-1:0] RegForever  = 2'd3;

  typedef enum logic {
    AluAdd,
    AluSub
  } alu_op_e;

  typedef struct packed {
    logic [TickW-1:0]  interval_time;
    logic [TickW-1:0]  initial_delay;
    logic [CountW-1:0] repeat_count;
    logic              run_forever;
  } cfg_t;

  // re-arm request from the register file
  typedef struct packed {
    logic arm;
    logic delay_nz;
  } arm_t;

  // flags from the shared arithmetic unit
  typedef struct packed {
    logic lt;      // a < b
    logic lt2;     // a < 2b, i.e. a - b < b
    logic eq;      // a == b
  } alu_flags_t;

endpackage
`default_nettype wire

### design/rdt_in_if.sv
// input channel: one elapsed-time word per update
`default_nettype none
interface rdt_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] tick_time;

  modport source (output valid, output tick_time, input ready);
  modport sink   (input valid, input tick_time, output ready);
endinterface
`default_nettype wire

### design/rdt_out_if.sv
// output channel: one word per fire
`default_nettype none
interface rdt_out_if;
  logic        valid;
  logic        ready;
  logic [39:0] fire_time;
  logic        cancelled;
  logic        last_fire;

  modport source (output valid, output fire_time, output cancelled, output last_fire,
                  input ready);
  modport sink   (input valid, input fire_time, input cancelled, input last_fire,
                  output ready);
endinterface
`default_nettype wire

### design/rdt_alu.sv
// shared 40-bit add/subtract and compare unit
`default_nettype none
module rdt_alu (
  input  wire logic [rdt_pkg::TimeW-1:0] a_i,
  input  wire logic [rdt_pkg::TimeW-1:0] b_i,
  input  wire rdt_pkg::alu_op_e          op_i,
  output logic [rdt_pkg::TimeW-1:0]      res_o,
  output rdt_pkg::alu_flags_t            flags_o
);

  logic [rdt_pkg::TimeW:0] sum;

  assign sum = {1'b0, a_i} + {1'b0, b_i};

  always_comb begin
    case (op_i)
      rdt_pkg::AluAdd: res_o = sum[rdt_pkg::TimeW] ? '1 : sum[rdt_pkg::TimeW-1:0];
      rdt_pkg::AluSub: res_o = a_i - b_i;
      default:         res_o = a_i - b_i;
    endcase
  end

  assign flags_o.lt  = a_i < b_i;
  assign flags_o.lt2 = {1'b0, a_i} < {b_i, 1'b0};
  assign flags_o.eq  = a_i == b_i;

endmodule
`default_nettype wire

### design/rdt_seq.sv
// sequencer: timer state, fire loop and output register
`default_nettype none
module rdt_seq #(
  parameter int unsigned MaxFires = rdt_pkg::MaxFiresDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire rdt_pkg::cfg_t cfg_i,
  input  wire rdt_pkg::arm_t arm_i,
  rdt_in_if.sink           tick_i,
  rdt_out_if.source        fire_o
);

  localparam int unsigned NW = $clog2(MaxFires + 1);

  localparam logic [2:0] SIdle  = 3'd0;
  localparam logic [2:0] SAdd   = 3'd1;
  localparam logic [2:0] SCheck = 3'd2;
  localparam logic [2:0] SDsub  = 3'd3;
  localparam logic [2:0] SDfire = 3'd4;
  localparam logic [2:0] SLoop  = 3'd5;

  logic [2:0]                  state_q, state_d;
  logic                        started_q, started_d;
  logic                        stopped_q, stopped_d;
  logic                        dpend_q, dpend_d;
  logic [rdt_pkg::TimeW-1:0]   elapsed_q, elapsed_d;
  logic [rdt_pkg::CountW-1:0]  count_q, count_d;
  logic [rdt_pkg::TimeW-1:0]   step_q, step_d;
  logic [rdt_pkg::TickW-1:0]   tick_q, tick_d;
  logic [NW-1:0]               n_q, n_d;
  logic                        ovalid_q, ovalid_d;
  logic [rdt_pkg::TimeW-1:0]   otime_q, otime_d;
  logic                        ocanc_q, ocanc_d;
  logic                        olast_q, olast_d;

  logic [rdt_pkg::TimeW-1:0]   alu_a, alu_b, alu_res, step_cand;
  rdt_pkg::alu_op_e            alu_op;
  rdt_pkg::alu_flags_t         alu_fl;
  logic [rdt_pkg::CountW-1:0]  cnt_inc;
  logic                        cancel, out_free;
  logic [NW-1:0]               n_inc;

  rdt_alu u_alu (
    .a_i     (alu_a),
    .b_i     (alu_b),
    .op_i    (alu_op),
    .res_o   (alu_res),
    .flags_o (alu_fl)
  );

  assign out_free  = !ovalid_q || fire_o.ready;
  assign cnt_inc   = (count_q == '1) ? count_q : count_q + 1'b1;
  assign cancel    = !cfg_i.run_forever && (cnt_inc > cfg_i.repeat_count);
  assign n_inc     = n_q + 1'b1;
  assign step_cand = (cfg_i.interval_time != '0) ?
                     {{(rdt_pkg::TimeW-rdt_pkg::TickW){1'b0}}, cfg_i.interval_time} :
                     elapsed_q;

  assign tick_i.ready = (state_q == SIdle);
  assign fire_o.valid     = ovalid_q;
  assign fire_o.fire_time = otime_q;
  assign fire_o.cancelled = ocanc_q;
  assign fire_o.last_fire = olast_q;

  // operand selection for the shared unit
  always_comb begin
    alu_a  = elapsed_q;
    alu_b  = step_q;
    alu_op = rdt_pkg::AluSub;
    case (state_q)
      SAdd: begin
        alu_b  = {{(rdt_pkg::TimeW-rdt_pkg::TickW){1'b0}}, tick_q};
        alu_op = rdt_pkg::AluAdd;
      end
      SCheck: begin
        alu_b = dpend_q ?
                {{(rdt_pkg::TimeW-rdt_pkg::TickW){1'b0}}, cfg_i.initial_delay} : step_cand;
      end
      SDsub: begin
        alu_b = {{(rdt_pkg::TimeW-rdt_pkg::TickW){1'b0}}, cfg_i.initial_delay};
      end
      SDfire: begin
        alu_b = step_cand;
      end
      default: begin
        alu_b = step_q;
      end
    endcase
  end

  always_comb begin
    state_d   = state_q;
    started_d = started_q;
    stopped_d = stopped_q;
    dpend_d   = dpend_q;
    elapsed_d = elapsed_q;
    count_d   = count_q;
    step_d    = step_q;
    tick_d    = tick_q;
    n_d       = n_q;
    ovalid_d  = ovalid_q && !fire_o.ready;
    otime_d   = otime_q;
    ocanc_d   = ocanc_q;
    olast_d   = olast_q;

    case (state_q)
      SIdle: begin
        if (tick_i.valid) begin
          if (stopped_q) begin
            state_d = SIdle;
          end else if (!started_q) begin
            started_d = 1'b1;
            elapsed_d = '0;
            count_d   = '0;
          end else begin
            tick_d  = tick_i.tick_time;
            n_d     = '0;
            state_d = SAdd;
          end
        end
      end
      SAdd: begin
        elapsed_d = alu_res;
        state_d   = SCheck;
      end
      SCheck: begin
        if (alu_fl.lt) begin
          state_d = SIdle;
        end else if (dpend_q) begin
          state_d = SDsub;
        end else begin
          step_d  = step_cand;
          state_d = SLoop;
        end
      end
      SDsub: begin
        elapsed_d = alu_res;
        dpend_d   = 1'b0;
        state_d   = SDfire;
      end
      SDfire: begin
        if (out_free) begin
          count_d   = cnt_inc;
          stopped_d = cancel;
          n_d       = n_inc;
          ovalid_d  = 1'b1;
          otime_d   = {{(rdt_pkg::TimeW-rdt_pkg::TickW){1'b0}}, cfg_i.initial_delay};
          ocanc_d   = cancel;
          olast_d   = cancel || (n_inc == NW'(MaxFires)) || alu_fl.lt;
          state_d   = (cancel || (n_inc == NW'(MaxFires)) || alu_fl.lt) ? SIdle : SCheck;
        end
      end
      SLoop: begin
        if (out_free) begin
          elapsed_d = alu_res;
          count_d   = cnt_inc;
          stopped_d = cancel;
          n_d       = n_inc;
          ovalid_d  = 1'b1;
          otime_d   = step_q;
          ocanc_d   = cancel;
          olast_d   = cancel || (n_inc == NW'(MaxFires)) || alu_fl.eq || alu_fl.lt2;
          state_d   = (cancel || (n_inc == NW'(MaxFires)) || alu_fl.eq || alu_fl.lt2) ?
                      SIdle : SLoop;
        end
      end
      default: begin
        state_d = SIdle;
      end
    endcase

    // re-arm on any register write
    if (arm_i.arm) begin
      started_d = 1'b0;
      stopped_d = 1'b0;
      dpend_d   = arm_i.delay_nz;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= SIdle;
      started_q <= 1'b0;
      stopped_q <= 1'b0;
      dpend_q   <= 1'b0;
      elapsed_q <= '0;
      count_q   <= '0;
      n_q       <= '0;
      ovalid_q  <= 1'b0;
    end else begin
      state_q   <= state_d;
      started_q <= started_d;
      stopped_q <= stopped_d;
      dpend_q   <= dpend_d;
      elapsed_q <= elapsed_d;
      count_q   <= count_d;
      n_q       <= n_d;
      ovalid_q  <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    step_q  <= step_d;
    tick_q  <= tick_d;
    otime_q <= otime_d;
    ocanc_q <= ocanc_d;
    olast_q <= olast_d;
  end

endmodule
`default_nettype wire

### design/repeating_delay_timer_top.sv
// top level of the repeating delay timer: registers, sequencer and checks
//
//  channel  dir  handshake        payload
//  tick_i   in   valid / ready    tick_time[31:0]  elapsed time, 16.16 seconds
//  fire_o   out  valid / ready    fire_time[39:0], cancelled, last_fire
//  cfg      in   cfg_we_i         cfg_idx_i[1:0], cfg_wdata_i[31:0]
//
// an update word is added and checked, then the initial delay is taken off and fired when
// due, then one fire word per cycle while fire_o is unstalled, up to MaxFires per update
// every step goes through the one shared 40-bit add/subtract/compare unit
// tick_i.ready is high only while the sequencer is idle; a stalled fire_o holds
// the fire loop, the output register can load a new word in the cycle the held one is taken
// rst_ni clears control state, elapsed time, count and cfg at once, no clearing pass
`default_nettype none
module repeating_delay_timer_top #(
  parameter int unsigned MaxFires = rdt_pkg::MaxFiresDef
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [rdt_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [rdt_pkg::CfgDataW-1:0]  cfg_wdata_i,
  rdt_in_if.sink                             tick_i,
  rdt_out_if.source                          fire_o
);

  rdt_pkg::cfg_t cfg_q, cfg_d;
  rdt_pkg::arm_t arm;

  // register file; every write re-arms the timer
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        rdt_pkg::RegInterval: cfg_d.interval_time = cfg_wdata_i;
        rdt_pkg::RegDelay:    cfg_d.initial_delay = cfg_wdata_i;
        rdt_pkg::RegRepeat:   cfg_d.repeat_count  = cfg_wdata_i;
        rdt_pkg::RegForever:  cfg_d.run_forever   = cfg_wdata_i[0];
        default:              cfg_d = cfg_q;
      endcase
    end
  end

  // delay pending follows the value being written, not the old one
  assign arm.arm      = cfg_we_i;
  assign arm.delay_nz = cfg_d.initial_delay != '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  rdt_seq #(
    .MaxFires (MaxFires)
  ) u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_q),
    .arm_i  (arm),
    .tick_i (tick_i),
    .fire_o (fire_o)
  );

  // a cancelling fire always ends its update
  a_cancel_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_o.valid && fire_o.cancelled |-> fire_o.last_fire)
    else $error("cancelled word not marked last");

  // a timer that runs forever never cancels
  a_forever: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_o.valid && cfg_q.run_forever |-> !fire_o.cancelled)
    else $error("cancel while run_forever set");

  // a zero-time step always ends the loop, so a non-final word carries time
  a_nonlast_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_o.valid && !fire_o.last_fire |-> fire_o.fire_time != '0)
    else $error("zero time on a non-final fire");

  // no update is taken while the loop runs, so a stalled non-final word keeps its time
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tick_i.valid && tick_i.ready && !fire_o.last_fire && fire_o.valid && !fire_o.ready
    |=> !(fire_o.valid && fire_o.fire_time != $past(fire_o.fire_time)))
    else $error("output word changed while stalled after an update was taken");

endmodule
`default_nettype wire

### tb/timer_fire_checker.sv
// fire word checker: mirrors the timer registers, predicts fire words and compares them
`timescale 1ns / 100ps
module timer_fire_checker
  import rdt_pkg::*;
#(
  parameter int unsigned MaxFires = MaxFiresDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  rdt_in_if                   tick_i,
  rdt_out_if                  fire_i,
  output int                  errors_o,
  output int                  pending_o,
  output int                  live_updates_o,
  output int                  updates_o,
  output int                  fires_checked_o,
  output int                  cancels_o
);

  typedef struct packed {
    logic [TimeW-1:0] fire_time;
    logic             cancelled;
    logic             last_fire;
  } fire_word_t;

  fire_word_t fires_due_q[$];

  // register mirror
  logic [TickW-1:0]  interval_time;
  logic [TickW-1:0]  initial_delay;
  logic [CountW-1:0] repeat_count;
  logic              run_forever;

  // timer state
  logic              started;
  logic [TimeW-1:0]  elapsed;
  logic [CountW-1:0] fire_count;
  logic              delay_pending;
  logic              stopped;

  int mismatches    = 0;
  int live_updates  = 0;
  int updates       = 0;
  int fires_checked = 0;
  int cancels       = 0;

  assign errors_o        = mismatches;
  assign live_updates_o  = live_updates;
  assign updates_o       = updates;
  assign fires_checked_o = fires_checked;
  assign cancels_o       = cancels;

  task automatic report_mismatch(input string msg);
    $display("[%0t] fire word mismatch: %s", $time, msg);
    mismatches++;
  endtask

  // bump the saturating fire count and apply the cancel rule
  function automatic bit count_fire();
    bit cancel;
    if (fire_count != '1) fire_count = fire_count + 1'b1;
    cancel = !run_forever && (fire_count > repeat_count);
    if (cancel) stopped = 1'b1;
    return cancel;
  endfunction

  task automatic predict_fires(input logic [TickW-1:0] tick);
    fire_word_t       batch [MaxFires];
    logic [TimeW:0]   sum;
    logic [TimeW-1:0] step;
    int               n;
    bit               cut;
    bit               done;
    n = 0;
    cut = 1'b0;
    done = 1'b0;
    if (stopped) return;
    live_updates++;
    if (!started) begin
      started = 1'b1;
      elapsed = '0;
      fire_count = '0;
      return;
    end
    sum = {1'b0, elapsed} + (TimeW + 1)'(tick);
    elapsed = sum[TimeW] ? '1 : sum[TimeW-1:0];
    if (delay_pending) begin
      if (elapsed < TimeW'(initial_delay)) return;
      elapsed = elapsed - TimeW'(initial_delay);
      delay_pending = 1'b0;
      cut = count_fire();
      batch[n] = {TimeW'(initial_delay), cut, 1'b0};
      n++;
    end
    if (!cut) begin
      step = (interval_time != '0) ? TimeW'(interval_time) : elapsed;
      while (!done && n < int'(MaxFires) && elapsed >= step) begin
        elapsed = elapsed - step;
        cut = count_fire();
        batch[n] = {step, cut, 1'b0};
        n++;
        done = cut || (elapsed == '0);
      end
    end
    for (int i = 0; i < n; i++) begin
      if (i == n - 1) batch[i].last_fire = 1'b1;
      fires_due_q.push_back(batch[i]);
    end
  endtask

  task automatic check_fire_word();
    fire_word_t want;
    if (fires_due_q.size() == 0) begin
      report_mismatch($sformatf("unexpected word time=%h cancelled=%b last=%b",
                                fire_i.fire_time, fire_i.cancelled, fire_i.last_fire));
      return;
    end
    want = fires_due_q.pop_front();
    fires_checked++;
    if (want.cancelled) cancels++;
    if (fire_i.fire_time !== want.fire_time)
      report_mismatch($sformatf("fire_time %h, want %h", fire_i.fire_time, want.fire_time));
    if (fire_i.cancelled !== want.cancelled)
      report_mismatch($sformatf("cancelled %b, want %b", fire_i.cancelled, want.cancelled));
    if (fire_i.last_fire !== want.last_fire)
      report_mismatch($sformatf("last_fire %b, want %b", fire_i.last_fire, want.last_fire));
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      interval_time = '0;
      initial_delay = '0;
      repeat_count  = '0;
      run_forever   = 1'b0;
      started       = 1'b0;
      elapsed       = '0;
      fire_count    = '0;
      delay_pending = 1'b0;
      stopped       = 1'b0;
      fires_due_q.delete();
      pending_o <= 0;
    end else begin
      if (fire_i.valid && fire_i.ready) check_fire_word();
      if (cfg_we_i) begin
        case (cfg_idx_i)
          RegInterval: interval_time = cfg_wdata_i;
          RegDelay:    initial_delay = cfg_wdata_i;
          RegRepeat:   repeat_count  = cfg_wdata_i;
          RegForever:  run_forever   = cfg_wdata_i[0];
          default: ;
        endcase
        // any write re-arms
        started       = 1'b0;
        stopped       = 1'b0;
        delay_pending = (initial_delay != '0);
      end
      if (tick_i.valid && tick_i.ready) begin
        updates++;
        predict_fires(tick_i.tick_time);
      end
      pending_o <= fires_due_q.size();
    end
  end

endmodule

### tb/tb_repeating_delay_timer_top.sv
// testbench top: drives ticks and register writes into the timer and gives the verdict
`timescale 1ns / 100ps
module tb_repeating_delay_timer_top;
  import rdt_pkg::*;

  localparam int ResetCycles  = 12;
  localparam int SettleCycles = 10;     // covers an update that makes no fire word
  localparam int TailCycles   = 40;
  localparam int RandomItems  = 210;    // tick words offered in the random part
  localparam int CalmItems    = 40;     // near-max ticks; each after the first fills the per-update fire cap
  localparam int IdlePct      = 27;
  localparam int CycleLimit   = 600000;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_idx;
  logic [CfgDataW-1:0] cfg_wdata;
  logic                calm;            // high during the stretch with no idling on either side

  logic [TickW-1:0] cur_interval;       // what was last programmed, used to shape ticks
  logic [TickW-1:0] cur_delay;

  int errors;
  int pending;
  int live_updates;
  int updates;
  int fires_checked;
  int cancels;
  int cycles = 0;
  int settings = 0;

  rdt_in_if  tick_if ();
  rdt_out_if fire_if ();

  repeating_delay_timer_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .tick_i      (tick_if),
    .fire_o      (fire_if)
  );

  timer_fire_checker checker_i (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_wdata_i     (cfg_wdata),
    .tick_i          (tick_if),
    .fire_i          (fire_if),
    .errors_o        (errors),
    .pending_o       (pending),
    .live_updates_o  (live_updates),
    .updates_o       (updates),
    .fires_checked_o (fires_checked),
    .cancels_o       (cancels)
  );

  // 10 ns clock
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // fire sink stalls at random, except in the calm stretch
  always @(posedge clk_i) begin
    fire_if.ready <= calm || ($urandom_range(0, 99) >= IdlePct);
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("watchdog expired after %0d cycles, %0d fire words still due", cycles, pending);
      $display("repeating_delay_timer_top regression: fail");
      $finish;
    end
  end

  // one register write per edge; caller drops cfg_we after the last one
  task automatic put_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    case (idx)
      RegInterval: cur_interval = val;
      RegDelay:    cur_delay    = val;
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  // block idle: no word offered, every predicted fire word seen, sequencer back to ready
  task automatic wait_idle();
    tick_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0 || !tick_if.ready) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic program_timer(input logic [TickW-1:0]  interval,
                               input logic [TickW-1:0]  delay,
                               input logic [CountW-1:0] rpt,
                               input logic              forever_on);
    wait_idle();
    put_reg(RegInterval, interval);
    put_reg(RegDelay, delay);
    put_reg(RegRepeat, rpt);
    put_reg(RegForever, CfgDataW'(forever_on));
    cfg_we <= 1'b0;
    settings++;
  endtask

  // offer one tick word, with random gaps in front of it outside the calm stretch
  task automatic send_tick(input logic [TickW-1:0] t);
    while (!calm && $urandom_range(0, 99) < IdlePct) begin
      tick_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    tick_if.valid     <= 1'b1;
    tick_if.tick_time <= t;
    @(posedge clk_i);
    while (!tick_if.ready) @(posedge clk_i);
  endtask

  // time values: zero, tiny, moderate, wide random and the top value
  function automatic logic [TickW-1:0] pick_time();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return $urandom_range(1, 16);
      2: return $urandom_range(1, 32'h0002_0000);
      3: return $urandom_range(32'h100, 32'h0010_0000);
      4: return $urandom;
      default: return '1;
    endcase
  endfunction

  function automatic logic [CountW-1:0] pick_repeat();
    case ($urandom_range(0, 9))
      0: return '0;
      1, 2: return $urandom_range(1, 8);
      3, 4, 5: return $urandom_range(9, 200);
      6, 7: return $urandom;
      default: return '1;
    endcase
  endfunction

  initial begin
    logic [TickW-1:0]   tick;
    logic [63:0]        wide;
    logic [CfgIdxW-1:0] reg_idx;
    int                 sent;
    int                 phase_len;

    rst_ni            = 1'b0;
    cfg_we            = 1'b0;
    cfg_idx           = '0;
    cfg_wdata         = '0;
    calm              = 1'b0;
    cur_interval      = '0;
    cur_delay         = '0;
    tick_if.valid     = 1'b0;
    tick_if.tick_time = '0;
    fire_if.ready     = 1'b0;

    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // --- directed part ---

    // reset settings: zero interval fires with the whole elapsed time, repeat 0 cancels,
    // then the stopped timer ignores updates
    send_tick(32'h0001_0000);
    send_tick(32'h0002_0000);
    send_tick(32'h1234_5678);

    // delay not reached, delay reached exactly, then interval fires up to the cancel
    program_timer(32'h0000_8000, 32'h0001_0000, 32'd3, 1'b0);
    send_tick('1);
    send_tick(32'h0000_4000);
    send_tick(32'h0000_C000);
    send_tick(32'h0001_8000);
    send_tick(32'h0000_8000);

    // zero interval, run forever: fires with zero elapsed, then with one lsb
    program_timer('0, '0, '0, 1'b1);
    send_tick('0);
    send_tick('0);
    send_tick(32'h0000_0001);

    // smallest interval with the largest tick: fires past the per-update cap are deferred
    program_timer(32'h0000_0001, '0, '1, 1'b0);
    send_tick('0);
    send_tick('1);
    send_tick('0);
    send_tick('0);

    // largest interval and delay
    program_timer('1, '1, 32'd1, 1'b0);
    send_tick('0);
    send_tick('1);
    send_tick('1);

    // the delay fire itself cancels
    program_timer(32'd5, 32'd3, '0, 1'b0);
    send_tick(32'h0000_0007);
    send_tick(32'h0000_0010);

    // a single register write re-arms the stopped timer
    wait_idle();
    put_reg(RegForever, '0);
    cfg_we <= 1'b0;
    send_tick(32'h0000_0007);
    send_tick(32'h0000_0009);

    // --- calm stretch: no idling anywhere, updates after the first hit the fire cap ---
    program_timer(32'h0000_0001, '0, '1, 1'b0);
    calm <= 1'b1;
    for (int i = 0; i < CalmItems; i++) send_tick($urandom | 32'hFFFF_F000);
    wait_idle();
    calm <= 1'b0;

    // --- random part: short phases of random settings ---
    sent = 0;
    while (sent < RandomItems) begin
      program_timer(pick_time(), ($urandom_range(0, 2) == 0) ? pick_time() : '0,
                    pick_repeat(), $urandom_range(0, 3) == 0);
      phase_len = $urandom_range(8, 24);
      for (int k = 0; k < phase_len && sent < RandomItems; k++) begin
        // occasional re-arm through one register
        if ($urandom_range(0, 99) < 10) begin
          wait_idle();
          reg_idx = CfgIdxW'($urandom_range(0, 3));
          case (reg_idx)
            RegForever: put_reg(reg_idx, CfgDataW'($urandom_range(0, 1)));
            RegRepeat:  put_reg(reg_idx, pick_repeat());
            default:    put_reg(reg_idx, pick_time());
          endcase
          cfg_we <= 1'b0;
        end
        // half the ticks sized around the interval, the rest noise
        case ($urandom_range(0, 9))
          0: tick = '0;
          1: tick = '1;
          2: tick = $urandom;
          3: tick = $urandom_range(0, 255);
          4: tick = $urandom_range(0, cur_delay);
          default: begin
            if (cur_interval == '0) begin
              tick = $urandom_range(0, 32'h0004_0000);
            end else begin
              wide = 64'(cur_interval) * 64'($urandom_range(0, 3))
                   + 64'($urandom_range(0, cur_interval));
              tick = (wide > 64'hFFFF_FFFF) ? '1 : wide[31:0];
            end
          end
        endcase
        send_tick(tick);
        sent++;
      end
    end

    // drain and watch for stray words
    wait_idle();
    repeat (TailCycles) @(posedge clk_i);

    $display("run covered %0d tick words (%0d acted on) across %0d timer settings",
             updates, live_updates, settings);
    $display("%0d fire words checked, %0d cancelling; fire cap hit back to back when calm",
             fires_checked, cancels);
    if (errors == 0) begin
      $display("repeating_delay_timer_top regression: pass");
    end else begin
      $display("repeating_delay_timer_top regression: fail");
    end
    $finish;
  end

endmodule
